/* rtl/dcpi_pkg.sv */
// Package for the drive cycle profile interpolator: table size, field widths,
// phase codes, breakpoint reset values, the shared restoring divide step.
// No dependencies.
package dcpi_pkg;

    localparam int NUM_POINTS = 8;                 // breakpoints in use, 2..8
    localparam int REG_COUNT  = 8;                 // breakpoint registers
    localparam int NUM_SEGS   = NUM_POINTS - 1;
    localparam int PT_IDX_W   = $clog2(REG_COUNT);
    localparam int CFG_IDX_W  = 8;

    localparam int TIME_W    = 16;
    localparam int SPD_W     = 16;
    localparam int RPM_W     = 16;
    localparam int MOD_STEPS = TIME_W;             // one remainder bit per stage
    localparam int DIV_STEPS = SPD_W;              // one quotient bit per stage

    localparam logic [15:0] RPM_MUL = 16'd57945;   // 65536 / (10 * 60 * 1.885 / 1000)

    typedef enum logic [1:0] {
        PHASE_IDLE   = 2'd0,
        PHASE_ACCEL  = 2'd1,
        PHASE_CRUISE = 2'd2,
        PHASE_DECEL  = 2'd3
    } t_phase;

    localparam logic [31:0] RESET_POINTS [REG_COUNT] = '{
        32'd0, 32'd327680, 32'd1311220, 32'd2294260,
        32'd3277700, 32'd4588420, 32'd5570560, 32'd6225920
    };

    // Segment data carried alongside the divider
    typedef struct packed {
        logic [SPD_W-1:0]  v0;
        logic              neg;
        logic              zlen;
        logic              found;
        t_phase            phase;
        logic [TIME_W-1:0] den;
    } t_seg;

    // One restoring step: shift in a dividend bit, subtract when it fits.
    // Returns {quotient bit, new remainder}; a remainder below the divisor stays below it.
    function automatic logic [TIME_W:0] div_step(
        input logic [TIME_W-1:0] rem,
        input logic              bit_in,
        input logic [TIME_W-1:0] dsr
    );
        logic [TIME_W:0] x;
        logic [TIME_W:0] d;
        logic [TIME_W:0] diff;
        x    = {rem, bit_in};
        d    = {1'b0, dsr};
        diff = x - d;
        if (x >= d) begin
            return {1'b1, diff[TIME_W-1:0]};
        end else begin
            return {1'b0, x[TIME_W-1:0]};
        end
    endfunction

endpackage

/* rtl/drive_cycle_profile_interpolator.sv */
// Drive cycle profile interpolator: top level with the full pipeline.
// Depends on dcpi_pkg (widths, phase codes, reset table, divide step).
//
// Usage
//   Input channel: i_in_valid / o_in_ready carry one sample time in seconds.
//   Output channel: o_out_valid / i_out_ready carry speed in tenths of km/h,
//   wheel rpm and drive phase, exactly one result per input transfer, in order.
//   Config channel: i_cfg_valid / o_cfg_ready write breakpoint i_cfg_index
//   (time in bits 31:16, speed in 15:0). Indexes past the table are dropped.
//   Write the table only while the pipeline is empty.
// Timing
//   From input transfer to o_out_valid: 16 stages of sample-modulo-period,
//   segment match, segment select, multiply, 16 stages of restoring divide,
//   combine, rpm multiply into the output register. Each divide stage resolves
//   one bit; throughput is one transfer per cycle unless the output stalls.
// Stall
//   When the output register holds a result the receiver does not take, the
//   whole pipeline holds and o_in_ready drops; nothing is lost or repeated.
// Reset
//   Synchronous, active low: all stage valids clear, the table returns to its
//   default drive cycle. The config port is always ready.
module drive_cycle_profile_interpolator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [dcpi_pkg::TIME_W-1:0]    i_sample_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dcpi_pkg::SPD_W-1:0]     o_speed_tenths_kmh,
    output logic [dcpi_pkg::RPM_W-1:0]     o_wheel_rpm,
    output logic [1:0]                     o_drive_phase,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dcpi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import dcpi_pkg::*;

    // Breakpoint table
    logic [31:0] r_point [REG_COUNT];

    // Global advance: the pipeline moves unless the output is held
    logic w_adv;
    logic r_out_vld;

    // Modulo stages
    logic              r_md_vld [MOD_STEPS];
    logic [TIME_W-1:0] r_md_rem [MOD_STEPS];
    logic [TIME_W-1:0] r_md_smp [MOD_STEPS];
    logic [TIME_W:0]   n_md_step [MOD_STEPS];

    // Match stage
    logic              r_m_vld;
    logic [TIME_W-1:0] r_m_t;
    logic [NUM_SEGS-1:0] r_m_hit;
    logic [TIME_W-1:0] n_m_t;
    logic [NUM_SEGS-1:0] n_m_hit;
    logic [TIME_W-1:0] w_period;

    // Select stage
    logic              r_l_vld;
    t_seg              r_l_seg;
    logic [TIME_W-1:0] r_l_dt;
    logic [SPD_W-1:0]  r_l_mag;
    t_seg              n_l_seg;
    logic [TIME_W-1:0] n_l_dt;
    logic [SPD_W-1:0]  n_l_mag;
    logic [TIME_W-1:0] w_t0;
    logic [TIME_W-1:0] w_t1;
    logic [SPD_W-1:0]  w_v0;
    logic [SPD_W-1:0]  w_v1;

    // Multiply stage
    logic              r_p_vld;
    t_seg              r_p_seg;
    logic [31:0]       r_p_prod;

    // Divide stages
    logic              r_dv_vld [DIV_STEPS];
    t_seg              r_dv_seg [DIV_STEPS];
    logic [TIME_W-1:0] r_dv_rem [DIV_STEPS];
    logic [TIME_W-1:0] r_dv_lo  [DIV_STEPS];
    logic [SPD_W-1:0]  r_dv_quo [DIV_STEPS];
    logic [TIME_W:0]   n_dv_step [DIV_STEPS];

    // Combine stage
    logic              r_c_vld;
    logic [SPD_W-1:0]  r_c_speed;
    t_phase            r_c_phase;
    logic [SPD_W-1:0]  n_c_speed;
    t_phase            n_c_phase;

    // Output register
    logic [SPD_W-1:0]  r_out_speed;
    logic [RPM_W-1:0]  r_out_rpm;
    t_phase            r_out_phase;
    logic [31:0]       w_rpm_prod;

    assign w_adv       = !r_out_vld || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // Configuration: drop writes beyond the table
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_point[k] <= RESET_POINTS[k];
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(REG_COUNT))) begin
            r_point[i_cfg_index[PT_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------------
    // Fold sample time into one period: one remainder bit per stage
    // ---------------------------------------------------------------------
    assign w_period = r_point[NUM_POINTS-1][31:16];

    always_comb begin
        n_md_step[0] = div_step('0, i_sample_time[TIME_W-1], w_period);
        for (int j = 1; j < MOD_STEPS; j++) begin
            n_md_step[j] = div_step(r_md_rem[j-1], r_md_smp[j-1][TIME_W-1], w_period);
        end
    end

    // ---------------------------------------------------------------------
    // Segment match: every segment compared in parallel
    // ---------------------------------------------------------------------
    always_comb begin
        n_m_t = (w_period == '0) ? '0 : r_md_rem[MOD_STEPS-1];
        for (int k = 0; k < NUM_SEGS; k++) begin
            n_m_hit[k] = (n_m_t >= r_point[k][31:16]) && (n_m_t <= r_point[k+1][31:16]);
        end
    end

    // ---------------------------------------------------------------------
    // Segment select: lowest hit wins, then deltas and phase
    // ---------------------------------------------------------------------
    always_comb begin
        w_t0 = '0;
        w_t1 = '0;
        w_v0 = '0;
        w_v1 = '0;
        n_l_seg.found = 1'b0;
        for (int k = NUM_SEGS - 1; k >= 0; k--) begin
            if (r_m_hit[k]) begin
                w_t0 = r_point[k][31:16];
                w_t1 = r_point[k+1][31:16];
                w_v0 = r_point[k][15:0];
                w_v1 = r_point[k+1][15:0];
                n_l_seg.found = 1'b1;
            end
        end
        n_l_seg.v0   = w_v0;
        n_l_seg.den  = w_t1 - w_t0;
        n_l_seg.zlen = (w_t1 == w_t0);
        n_l_seg.neg  = (w_v1 < w_v0);
        n_l_dt       = r_m_t - w_t0;
        n_l_mag      = n_l_seg.neg ? (w_v0 - w_v1) : (w_v1 - w_v0);
        if (w_v1 > w_v0) begin
            n_l_seg.phase = PHASE_ACCEL;
        end else if (w_v1 < w_v0) begin
            n_l_seg.phase = PHASE_DECEL;
        end else if (w_v0 == '0) begin
            n_l_seg.phase = PHASE_IDLE;
        end else begin
            n_l_seg.phase = PHASE_CRUISE;
        end
    end

    // ---------------------------------------------------------------------
    // Divide |dv|*dt by segment length. The quotient never exceeds |dv|, so
    // the upper dividend half starts as the remainder and 16 steps suffice.
    // ---------------------------------------------------------------------
    always_comb begin
        n_dv_step[0] = div_step(r_p_prod[31:16], r_p_prod[15], r_p_seg.den);
        for (int j = 1; j < DIV_STEPS; j++) begin
            n_dv_step[j] = div_step(r_dv_rem[j-1], r_dv_lo[j-1][TIME_W-1],
                                    r_dv_seg[j-1].den);
        end
    end

    // ---------------------------------------------------------------------
    // Combine: apply sign, handle zero-length and unmatched segments
    // ---------------------------------------------------------------------
    always_comb begin
        if (!r_dv_seg[DIV_STEPS-1].found) begin
            n_c_speed = '0;
            n_c_phase = PHASE_IDLE;
        end else begin
            n_c_phase = r_dv_seg[DIV_STEPS-1].phase;
            if (r_dv_seg[DIV_STEPS-1].zlen) begin
                n_c_speed = r_dv_seg[DIV_STEPS-1].v0;
            end else if (r_dv_seg[DIV_STEPS-1].neg) begin
                n_c_speed = r_dv_seg[DIV_STEPS-1].v0 - r_dv_quo[DIV_STEPS-1];
            end else begin
                n_c_speed = r_dv_seg[DIV_STEPS-1].v0 + r_dv_quo[DIV_STEPS-1];
            end
        end
    end

    assign w_rpm_prod = 32'(r_c_speed) * 32'(RPM_MUL);

    // ---------------------------------------------------------------------
    // Stage valids: advance together, hold on a stalled output
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MOD_STEPS; j++) begin
                r_md_vld[j] <= 1'b0;
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_dv_vld[j] <= 1'b0;
            end
            r_m_vld   <= 1'b0;
            r_l_vld   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_md_vld[0] <= i_in_valid;
            for (int j = 1; j < MOD_STEPS; j++) begin
                r_md_vld[j] <= r_md_vld[j-1];
            end
            r_m_vld     <= r_md_vld[MOD_STEPS-1];
            r_l_vld     <= r_m_vld;
            r_p_vld     <= r_l_vld;
            r_dv_vld[0] <= r_p_vld;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
            r_c_vld   <= r_dv_vld[DIV_STEPS-1];
            r_out_vld <= r_c_vld;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_md_rem[0] <= n_md_step[0][TIME_W-1:0];
            r_md_smp[0] <= {i_sample_time[TIME_W-2:0], 1'b0};
            for (int j = 1; j < MOD_STEPS; j++) begin
                r_md_rem[j] <= n_md_step[j][TIME_W-1:0];
                r_md_smp[j] <= {r_md_smp[j-1][TIME_W-2:0], 1'b0};
            end

            r_m_t   <= n_m_t;
            r_m_hit <= n_m_hit;

            r_l_seg <= n_l_seg;
            r_l_dt  <= n_l_dt;
            r_l_mag <= n_l_mag;

            r_p_seg  <= r_l_seg;
            r_p_prod <= 32'(r_l_mag) * 32'(r_l_dt);

            r_dv_seg[0] <= r_p_seg;
            r_dv_rem[0] <= n_dv_step[0][TIME_W-1:0];
            r_dv_lo[0]  <= {r_p_prod[TIME_W-2:0], 1'b0};
            r_dv_quo[0] <= {{(SPD_W-1){1'b0}}, n_dv_step[0][TIME_W]};
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dv_seg[j] <= r_dv_seg[j-1];
                r_dv_rem[j] <= n_dv_step[j][TIME_W-1:0];
                r_dv_lo[j]  <= {r_dv_lo[j-1][TIME_W-2:0], 1'b0};
                r_dv_quo[j] <= {r_dv_quo[j-1][SPD_W-2:0], n_dv_step[j][TIME_W]};
            end

            r_c_speed <= n_c_speed;
            r_c_phase <= n_c_phase;

            r_out_speed <= r_c_speed;
            r_out_rpm   <= w_rpm_prod[31:16];
            r_out_phase <= r_c_phase;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_speed_tenths_kmh = r_out_speed;
    assign o_wheel_rpm        = r_out_rpm;
    assign o_drive_phase      = r_out_phase;

`ifndef SYNTHESIS
    // Wheel rpm scale is below one, so rpm never exceeds speed
    a_rpm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wheel_rpm <= o_speed_tenths_kmh))
        else $error("wheel rpm exceeds speed");

    // Idle phase only comes with standstill
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_drive_phase == PHASE_IDLE)) |-> (o_speed_tenths_kmh == '0))
        else $error("idle phase with nonzero speed");

    // Input is refused only while a result waits at the output
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input refused without output stall");

    // An input transfer enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_md_vld[0])
        else $error("accepted sample lost at pipeline entry");
`endif

endmodule

/* dv/tb_drive_cycle_profile_interpolator.sv */
// Self-checking testbench for drive_cycle_profile_interpolator: random and directed
// sample times over a series of breakpoint tables, checked against a predictor.
// Depends on dcpi_pkg and the RTL of the interpolator.
`timescale 1ns / 100ps

module tb_drive_cycle_profile_interpolator;
    import dcpi_pkg::*;

    // Breakpoints actually scanned by the block (NUM_POINTS clamped to the table)
    localparam int USED_PTS = (NUM_POINTS > REG_COUNT) ? REG_COUNT :
                              (NUM_POINTS < 2) ? 2 : NUM_POINTS;
    localparam int ITEMS_PER_TABLE = 46;
    localparam int STALL_LIMIT     = 4000;   // cycles without any transfer
    localparam int DRAIN_CYCLES    = 48;     // more than the full pipeline depth
    localparam int MAX_PRINTED     = 50;

    // Shapes of breakpoint table that the run steps through
    typedef enum int {
        PROF_ZERO,            // every register 0: period 0, zero-length segments
        PROF_ONES,            // every register all ones: no segment ever matches
        PROF_FULL_SWING,      // times across the whole range, speeds at 0 and max
        PROF_FLAT_STEPS,      // repeated times: zero-length segments
        PROF_DESCENDING,      // times falling: no segment matches
        PROF_NO_PERIOD,       // last time 0: every sample folds to 0
        PROF_RANDOM_SORTED,   // ascending times, random speeds
        PROF_RANDOM_RAW       // any register contents
    } t_profile_kind;

    typedef struct packed {
        logic [SPD_W-1:0] speed;
        logic [RPM_W-1:0] rpm;
        t_phase           phase;
    } t_drive_sample;

    localparam t_profile_kind TABLE_PLAN [12] = '{
        PROF_ZERO, PROF_ONES, PROF_FULL_SWING, PROF_FLAT_STEPS, PROF_DESCENDING,
        PROF_NO_PERIOD, PROF_RANDOM_SORTED, PROF_RANDOM_SORTED, PROF_RANDOM_SORTED,
        PROF_RANDOM_RAW, PROF_RANDOM_SORTED, PROF_RANDOM_SORTED
    };

    // Directed times against the default table (period 95): range ends, every
    // breakpoint, the period and its neighbors, and one point in each segment.
    localparam logic [TIME_W-1:0] SPOT_TIMES [20] = '{
        16'd0, 16'd65535, 16'd5, 16'd20, 16'd35, 16'd50, 16'd70, 16'd85, 16'd94, 16'd95,
        16'd96, 16'd1, 16'd12, 16'd27, 16'd42, 16'd60, 16'd77, 16'd90, 16'd190, 16'd32768
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [TIME_W-1:0]    i_sample_time = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [SPD_W-1:0]     o_speed_tenths_kmh;
    logic [RPM_W-1:0]     o_wheel_rpm;
    logic [1:0]           o_drive_phase;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    // Predictor copy of the breakpoint table, kept in step with config writes
    logic [31:0]          profile_pts [REG_COUNT];
    logic [TIME_W-1:0]    sample_queue [$];      // times waiting to be sent
    t_drive_sample        expected_samples [$];  // predictions, oldest first
    int unsigned          mismatch_count = 0;
    int unsigned          result_count = 0;
    int unsigned          quiet_cycles = 0;
    int                   send_gap = 0;
    int                   hold_len = 0;
    bit                   in_calm = 1'b0;
    bit                   out_calm = 1'b0;

    drive_cycle_profile_interpolator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_sample_time      (i_sample_time),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_speed_tenths_kmh (o_speed_tenths_kmh),
        .o_wheel_rpm        (o_wheel_rpm),
        .o_drive_phase      (o_drive_phase),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Fold the time into one period, find the first segment holding it,
    // interpolate with truncating division and classify from the end speeds.
    function automatic t_drive_sample predict_drive_sample(input logic [TIME_W-1:0] sample);
        t_drive_sample     r;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
        logic [SPD_W-1:0]  v0;
        logic [SPD_W-1:0]  v1;
        longint            step;
        logic [31:0]       prod;
        bit                hit;
        period  = profile_pts[USED_PTS-1][31:16];
        t       = (period != 0) ? sample % period : '0;
        r.speed = '0;
        r.phase = PHASE_IDLE;
        hit     = 1'b0;
        for (int k = 0; k + 1 < USED_PTS; k++) begin
            t0 = profile_pts[k][31:16];
            t1 = profile_pts[k+1][31:16];
            if (!hit && t >= t0 && t <= t1) begin
                hit = 1'b1;
                v0  = profile_pts[k][15:0];
                v1  = profile_pts[k+1][15:0];
                if (t1 == t0) begin
                    r.speed = v0;
                end else begin
                    step    = ((longint'(v1) - longint'(v0)) * longint'(t - t0)) /
                              longint'(t1 - t0);
                    r.speed = SPD_W'(longint'(v0) + step);
                end
                if (v1 > v0)      r.phase = PHASE_ACCEL;
                else if (v1 < v0) r.phase = PHASE_DECEL;
                else              r.phase = (v0 == 0) ? PHASE_IDLE : PHASE_CRUISE;
            end
        end
        prod  = {16'd0, r.speed} * {16'd0, RPM_MUL};
        r.rpm = prod[31:16];
        return r;
    endfunction

    // Mostly short gaps, some medium, a few long
    function automatic int pick_idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Favor times within two periods and right around breakpoints
    function automatic logic [TIME_W-1:0] pick_sample_time();
        logic [TIME_W-1:0] per;
        int unsigned       span;
        int unsigned       roll;
        per  = profile_pts[USED_PTS-1][31:16];
        span = 2 * per + 1;
        if (span > 65535) span = 65535;
        roll = $urandom_range(0, 9);
        if (roll < 6) return TIME_W'($urandom_range(0, span));
        if (roll < 8) return profile_pts[$urandom_range(0, USED_PTS-1)][31:16] +
                             TIME_W'($urandom_range(0, 2)) - 1'b1;
        return TIME_W'($urandom_range(0, 65535));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] result %0d %s: got %0d, expected %0d",
                     $realtime, result_count, what, got, want);
    endtask

    // One register write; hold valid across back-to-back writes
    task automatic write_point(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < REG_COUNT) profile_pts[idx] = val;
    endtask

    task automatic program_profile(input t_profile_kind kind);
        logic [15:0] tm [REG_COUNT];
        logic [15:0] sp [REG_COUNT];
        int unsigned step_max;
        step_max = ($urandom_range(0, 3) == 0) ? 9000 : 40;
        for (int k = 0; k < REG_COUNT; k++) begin
            case (kind)
                PROF_ZERO: begin
                    tm[k] = '0;
                    sp[k] = '0;
                end
                PROF_ONES: begin
                    tm[k] = '1;
                    sp[k] = '1;
                end
                PROF_FULL_SWING: begin
                    tm[k] = (k == REG_COUNT-1) ? 16'hFFFF : 16'(k * 9362);
                    sp[k] = (k inside {1, 2, 4, 7}) ? 16'hFFFF : 16'h0000;
                end
                PROF_FLAT_STEPS: begin
                    tm[k] = 16'(10 * ((k + 1) / 2));
                    sp[k] = 16'($urandom_range(0, 65535));
                end
                PROF_DESCENDING: begin
                    tm[k] = 16'(100 - 10 * k);
                    sp[k] = 16'($urandom_range(0, 65535));
                end
                PROF_NO_PERIOD: begin
                    tm[k] = (k == REG_COUNT-1 || $urandom_range(0, 1) == 0) ? 16'd0 :
                            16'($urandom_range(0, 65535));
                    sp[k] = 16'($urandom_range(0, 65535));
                end
                PROF_RANDOM_SORTED: begin
                    tm[k] = (k == 0) ? 16'($urandom_range(0, 3)) :
                            tm[k-1] + 16'($urandom_range(0, step_max));
                    case ($urandom_range(0, 9))
                        0, 1:    sp[k] = '0;
                        2, 3, 4: sp[k] = (k == 0) ? 16'd0 : sp[k-1];
                        default: sp[k] = 16'($urandom_range(0, 65535));
                    endcase
                end
                default: begin
                    tm[k] = 16'($urandom_range(0, 65535));
                    sp[k] = 16'($urandom_range(0, 65535));
                end
            endcase
        end
        for (int k = 0; k < REG_COUNT; k++)
            write_point(CFG_IDX_W'(k), {tm[k], sp[k]});
        // Index past the table: the block must drop it
        write_point(CFG_IDX_W'($urandom_range(REG_COUNT, 2**CFG_IDX_W - 1)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued time has been sent and every result checked
    task automatic wait_idle();
        while (sample_queue.size() != 0 || i_in_valid || expected_samples.size() != 0)
            @(posedge i_clk);
    endtask

    // Driver: present queued times, hold each until its transfer, predict on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_samples.push_back(predict_drive_sample(i_sample_time));
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    i_in_valid    <= 1'b1;
                    i_sample_time <= sample_queue.pop_front();
                    send_gap = in_calm ? 0 : pick_idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction,
    // and stall the receiver at random
    always @(posedge i_clk) begin : result_check
        t_drive_sample want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_len = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("with no sample pending", o_speed_tenths_kmh, 0);
                end else begin
                    want = expected_samples.pop_front();
                    if (o_speed_tenths_kmh !== want.speed)
                        report_mismatch("speed", o_speed_tenths_kmh, want.speed);
                    if (o_wheel_rpm !== want.rpm)
                        report_mismatch("wheel rpm", o_wheel_rpm, want.rpm);
                    if (o_drive_phase !== want.phase)
                        report_mismatch("drive phase", o_drive_phase, want.phase);
                end
                result_count++;
            end
            if (hold_len > 0) begin
                hold_len--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!out_calm && $urandom_range(0, 3) == 0) hold_len = pick_idle_len();
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_drive_cycle_profile_interpolator: FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        profile_pts = RESET_POINTS;

        // Default table: directed times first, then random ones
        foreach (SPOT_TIMES[i]) sample_queue.push_back(SPOT_TIMES[i]);
        repeat (ITEMS_PER_TABLE) sample_queue.push_back(pick_sample_time());
        wait_idle();

        // Reprogram only once the pipeline has drained
        foreach (TABLE_PLAN[p]) begin
            program_profile(TABLE_PLAN[p]);
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_TABLE) sample_queue.push_back(pick_sample_time());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_samples.size() != 0)
            report_mismatch("predictions left unanswered", 0, expected_samples.size());
        if (mismatch_count == 0) begin
            $display("tb_drive_cycle_profile_interpolator: PASS");
        end else begin
            $display("tb_drive_cycle_profile_interpolator: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/dcpi_pkg.sv
rtl/drive_cycle_profile_interpolator.sv
dv/tb_drive_cycle_profile_interpolator.sv
